// ===== hdl/plfh_pkg.sv =====
// Shared constants, types and reset image for the panel link frame handler.
package plfh_pkg;

    localparam int FRAME_LEN = 9;
    localparam int SUM_LEN   = FRAME_LEN - 1;
    localparam int POS_W     = 4;
    localparam int BYTE_W    = 8;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] SYNC_LAST = POS_W'(SUM_LEN - 1);

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hB0;
    localparam logic [BYTE_W-1:0] SEED_RESET = 8'h55;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_SEED   = 8'd1;

    localparam logic [BYTE_W-1:0] KEY_CLEAR = 8'h01;
    localparam logic [BYTE_W-1:0] KEY_INC1  = 8'h20;
    localparam logic [BYTE_W-1:0] KEY_INC2  = 8'h40;
    localparam logic [BYTE_W-1:0] KEY_INC3  = 8'h80;

    localparam logic [BYTE_W-1:0] TX_RESET [FRAME_LEN] = '{
        8'h0B, 8'h07, 8'h00, 8'h28, 8'h0F, 8'h20, 8'h04, 8'h00, 8'hC2
    };

    typedef struct packed {
        logic clear;
        logic inc1;
        logic inc2;
        logic inc3;
    } t_tx_upd;

endpackage

// ===== hdl/plfh_tx_frame.sv =====
// Transmit frame store with key-driven update and checksum recompute.
module plfh_tx_frame
    import plfh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [POS_W-1:0]  i_rd_idx,
    output logic [BYTE_W-1:0] o_rd_data,
    input  logic [BYTE_W-1:0] i_seed,
    input  t_tx_upd           i_upd
);

    logic [BYTE_W-1:0] r_frame [FRAME_LEN];
    logic [BYTE_W-1:0] n_frame [FRAME_LEN];
    logic [BYTE_W-1:0] n_sum;

    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            n_frame[i] = r_frame[i];
        end
        if (i_upd.clear) begin
            n_frame[1] = '0;
            n_frame[2] = '0;
            n_frame[3] = '0;
        end
        if (i_upd.inc1) begin
            n_frame[1] = r_frame[1] + 8'd1;
        end
        if (i_upd.inc2) begin
            n_frame[2] = r_frame[2] + 8'd1;
        end
        if (i_upd.inc3) begin
            n_frame[3] = r_frame[3] + 8'd1;
        end
        n_sum = i_seed;
        for (int i = 0; i < SUM_LEN; i++) begin
            n_sum = n_sum + n_frame[i];
        end
        if (|i_upd) begin
            n_frame[FRAME_LEN-1] = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_frame[i] <= TX_RESET[i];
            end
        end else begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_frame[i] <= n_frame[i];
            end
        end
    end

    assign o_rd_data = (i_rd_idx < POS_W'(FRAME_LEN)) ? r_frame[i_rd_idx] : '0;

endmodule

// ===== hdl/panel_link_frame_handler_core.sv =====
// Top level of the panel link frame handler: framing, checksum check and result stage.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata tx_byte, tlast frame_end, tuser flags
//  cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// Each item's answer is written to the result register when the item is accepted.
// A new item is accepted every cycle while the result register is empty or being drained.
// Reset restores the sync value, seed, transmit frame image and hunting state.
// A stalled result holds and blocks input only until it is taken.
module panel_link_frame_handler_core
    import plfh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] tx_byte
    output logic                 m_axis_tlast,
    output logic [3:0]           m_axis_tuser,   // [0] aligned, [1] sum_good, [2] fault,
                                                 // [3] frame_updated
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_FIRST,
        PH_CHECKED
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_rx_sum, n_rx_sum;
    logic [BYTE_W-1:0] r_key, n_key;
    logic              r_fault, n_fault;
    logic [BYTE_W-1:0] r_sync, r_seed;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_tx;
    logic              r_aligned, r_fend, r_good, r_upd;

    logic              accept;
    logic [POS_W-1:0]  pos, tx_idx;
    logic [BYTE_W-1:0] tx_data, rx, sum_base;
    logic              aligned, fend, good;
    t_tx_upd           upd, frame_upd;

    assign rx            = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_rx_sum = r_rx_sum;
        n_key    = r_key;
        n_fault  = r_fault;
        tx_idx   = '0;
        aligned  = 1'b0;
        fend     = 1'b0;
        good     = 1'b0;
        upd      = '0;
        pos      = '0;
        sum_base = r_rx_sum;
        case (r_phase)
            PH_HUNT: begin
                if (rx == r_sync) begin
                    n_phase = PH_SYNC;
                    n_pos   = '0;
                end
            end
            PH_SYNC: begin
                tx_idx = {1'b0, r_pos[2:0]};
                n_pos  = r_pos + 4'd1;
                if (r_pos >= SYNC_LAST) begin
                    n_phase = PH_FIRST;
                    n_pos   = '0;
                end
            end
            default: begin
                pos      = (r_pos > LAST_POS) ? '0 : r_pos;
                aligned  = 1'b1;
                tx_idx   = pos;
                sum_base = (pos == '0) ? r_seed : r_rx_sum;
                if (pos < LAST_POS) begin
                    n_rx_sum = sum_base + rx;
                end
                if (pos == 4'd1) begin
                    n_key = rx;
                end
                if (pos == LAST_POS) begin
                    fend  = 1'b1;
                    n_pos = '0;
                    if (r_phase == PH_FIRST) begin
                        good    = 1'b1;
                        n_phase = PH_CHECKED;
                    end else begin
                        good    = (r_rx_sum == rx);
                        n_fault = r_fault || !good;
                        if (!n_fault) begin
                            upd.clear = (r_key == KEY_CLEAR);
                            upd.inc1  = (r_key == KEY_INC1);
                            upd.inc2  = (r_key == KEY_INC2);
                            upd.inc3  = (r_key == KEY_INC3);
                        end
                    end
                end else begin
                    n_pos = pos + 4'd1;
                end
            end
        endcase
    end

    assign frame_upd = accept ? upd : '0;

    plfh_tx_frame u_tx_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (tx_idx),
        .o_rd_data (tx_data),
        .i_seed    (r_seed),
        .i_upd     (frame_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_pos       <= '0;
            r_rx_sum    <= '0;
            r_key       <= '0;
            r_fault     <= 1'b0;
            r_sync      <= SYNC_RESET;
            r_seed      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SYNC_VALUE) begin
                    r_sync <= i_cfg_data;
                end
                if (i_cfg_index == CFG_SUM_SEED) begin
                    r_seed <= i_cfg_data;
                end
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_rx_sum    <= n_rx_sum;
                r_key       <= n_key;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx      <= tx_data;
            r_aligned <= aligned;
            r_fend    <= fend;
            r_good    <= good;
            r_upd     <= |upd;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_tx;
    assign m_axis_tlast  = r_fend;
    assign m_axis_tuser  = {r_upd, r_fault, r_good, r_aligned};

    a_end_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("frame end reported outside an aligned frame");

    a_upd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast && m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("frame update without a good checked frame end");

    a_good_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[1])
        else $error("checksum result reported away from frame end");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("fault latch cleared without reset");

endmodule

// ===== tb/panel_link_frame_handler_core_test.sv =====
// Self-checking testbench for the panel link frame handler: directed and random byte exchanges.
`timescale 1ns / 100ps

module panel_link_frame_handler_core_test;
    import plfh_pkg::*;

    typedef enum logic [2:0] {
        LINK_HUNT,
        LINK_SYNC,
        LINK_FIRST,
        LINK_CHECKED
    } t_link_phase;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] tx;
        logic              aligned;
        logic              frame_end;
        logic              sum_good;
        logic              fault;
        logic              updated;
    } t_link_res;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    val;
        t_link_res            want;
    } t_stim_row;

    localparam int FRAMES_PER_PHASE = 28;
    localparam int RAND_PHASES      = 6;
    localparam int HOLD_CYCLES      = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic [3:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;

    panel_link_frame_handler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the link state.
    t_link_phase       link_ph   = LINK_HUNT;
    logic [POS_W-1:0]  pos_cnt   = '0;
    logic [BYTE_W-1:0] run_sum   = '0;
    logic [BYTE_W-1:0] key_val   = '0;
    logic [BYTE_W-1:0] tx_img [FRAME_LEN];
    logic              fault_seen = 1'b0;
    logic [BYTE_W-1:0] cur_sync  = SYNC_RESET;
    logic [BYTE_W-1:0] cur_seed  = SEED_RESET;

    t_link_res answer_q [$];
    t_link_res typed_answer;
    bit        typed_now     = 1'b0;
    int        fail_cnt      = 0;
    int        send_idle_pct = 29;
    int        recv_idle_pct = 79;
    bit        pressure_req  = 1'b0;
    t_stim_row dir_rows [$];

    initial tx_img = TX_RESET;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_link_res predict_answer(input logic [BYTE_W-1:0] rx);
        t_link_res        r;
        logic [POS_W-1:0] pos;
        logic [BYTE_W-1:0] s;
        r = '0;
        case (link_ph)
            LINK_HUNT: begin
                r.tx = tx_img[0];
                if (rx == cur_sync) begin
                    link_ph = LINK_SYNC;
                    pos_cnt = '0;
                end
            end
            LINK_SYNC: begin
                r.tx = tx_img[pos_cnt[2:0]];
                pos_cnt = pos_cnt + 1'b1;
                if (pos_cnt >= SUM_LEN) begin
                    link_ph = LINK_FIRST;
                    pos_cnt = '0;
                end
            end
            default: begin
                pos = (pos_cnt >= FRAME_LEN) ? '0 : pos_cnt;
                r.aligned = 1'b1;
                r.tx = tx_img[pos];
                if (pos == 0) run_sum = cur_seed;
                if (pos < SUM_LEN) run_sum = run_sum + rx;
                if (pos == 1) key_val = rx;
                if (pos == LAST_POS) begin
                    r.frame_end = 1'b1;
                    if (link_ph == LINK_FIRST) begin
                        r.sum_good = 1'b1;
                        link_ph = LINK_CHECKED;
                    end else begin
                        r.sum_good = (run_sum == rx);
                        if (!r.sum_good) fault_seen = 1'b1;
                        if (!fault_seen) begin
                            case (key_val)
                                KEY_CLEAR: begin
                                    tx_img[1] = '0;
                                    tx_img[2] = '0;
                                    tx_img[3] = '0;
                                    r.updated = 1'b1;
                                end
                                KEY_INC1: begin
                                    tx_img[1] = tx_img[1] + 1'b1;
                                    r.updated = 1'b1;
                                end
                                KEY_INC2: begin
                                    tx_img[2] = tx_img[2] + 1'b1;
                                    r.updated = 1'b1;
                                end
                                KEY_INC3: begin
                                    tx_img[3] = tx_img[3] + 1'b1;
                                    r.updated = 1'b1;
                                end
                                default: ;
                            endcase
                            if (r.updated) begin
                                s = cur_seed;
                                for (int i = 0; i < SUM_LEN; i++) s = s + tx_img[i];
                                tx_img[SUM_LEN] = s;
                            end
                        end
                    end
                    pos_cnt = '0;
                end else begin
                    pos_cnt = pos + 1'b1;
                end
            end
        endcase
        r.fault = fault_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_link_res got;
        t_link_res want;
        t_link_res pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                       m_axis_tuser[2], m_axis_tuser[3]};
                if (answer_q.size() == 0) begin
                    $display("%0t: result with no expectation, expected none, got %0h",
                             $time, got);
                    fail_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("tx_byte", want.tx, got.tx);
                    check_field("aligned", 8'(want.aligned), 8'(got.aligned));
                    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
                    check_field("sum_good", 8'(want.sum_good), 8'(got.sum_good));
                    check_field("fault", 8'(want.fault), 8'(got.fault));
                    check_field("frame_updated", 8'(want.updated), 8'(got.updated));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_answer(s_axis_tdata);
                answer_q.push_back(typed_now ? typed_answer : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SYNC_VALUE) begin
                    cur_sync = i_cfg_data;
                end else if (i_cfg_index == CFG_SUM_SEED) begin
                    cur_seed = i_cfg_data;
                end
            end
        end
    end

    // The receiver side, including one long hold-off once the pressure request is raised.
    initial begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [7:0] rx, input bit typed, input t_link_res want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        typed_now = typed;
        typed_answer = want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A frame with random payload; the key byte mostly selects an update.
    task automatic send_frame(input logic [BYTE_W-1:0] seed, input bit allow_bad);
        logic [BYTE_W-1:0] fr [FRAME_LEN];
        logic [BYTE_W-1:0] s;
        for (int i = 0; i < SUM_LEN; i++) fr[i] = 8'($urandom);
        case ($urandom_range(0, 5))
            0: fr[1] = KEY_CLEAR;
            1: fr[1] = KEY_INC1;
            2: fr[1] = KEY_INC2;
            3: fr[1] = KEY_INC3;
            default: ;
        endcase
        s = seed;
        for (int i = 0; i < SUM_LEN; i++) s = s + fr[i];
        fr[SUM_LEN] = s;
        if (allow_bad && $urandom_range(0, 3) == 0) begin
            fr[SUM_LEN] = s ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < FRAME_LEN; i++) send_item(fr[i], 1'b0, '0);
    endtask

    task automatic add_item(input logic [7:0] rx, input t_link_res want);
        dir_rows.push_back('{ROW_ITEM, '0, rx, want});
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        dir_rows.push_back('{ROW_CFG, idx, val, '0});
    endtask

    initial begin : stimulus
        logic [7:0] sync_rx [SUM_LEN];
        logic [7:0] first_rx [FRAME_LEN];
        logic [BYTE_W-1:0] seed;
        int waited;
        sync_rx = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        first_rx = '{8'hC3, KEY_INC1, 8'hFF, 8'h00, 8'h3C, 8'h81, 8'h18, 8'hE7, 8'h13};

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;

        // Hunting bytes answer with tx byte 0, the sync byte itself too.
        add_item(8'h00, {8'h0B, 5'b00000});
        add_item(8'hFF, {8'h0B, 5'b00000});
        add_cfg(CFG_SYNC_VALUE, 8'h00);
        add_item(8'hB0, {8'h0B, 5'b00000});
        add_cfg(CFG_SYNC_VALUE, 8'hFF);
        add_item(8'hFF, {8'h0B, 5'b00000});
        // The sync run is answered with tx bytes 0..7, still unaligned.
        for (int i = 0; i < SUM_LEN; i++) add_item(sync_rx[i], {TX_RESET[i], 5'b00000});
        add_cfg(8'hFF, 8'hAA);
        add_cfg(CFG_SUM_SEED, 8'h00);
        // The first aligned frame is unchecked and never updates.
        for (int i = 0; i < SUM_LEN; i++) add_item(first_rx[i], {TX_RESET[i], 5'b10000});
        add_item(first_rx[SUM_LEN], {TX_RESET[SUM_LEN], 5'b11100});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_item(dir_rows[r].val, 1'b1, dir_rows[r].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seed = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom);
            write_reg(CFG_SUM_SEED, seed);
            write_reg(CFG_SYNC_VALUE, 8'($urandom));
            write_reg(8'($urandom_range(2, 255)), 8'($urandom));
            if (ph == 4) pressure_req = 1'b1;
            for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
                send_frame(seed, ph == RAND_PHASES - 1);
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (answer_q.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (5) @(negedge i_clk);
        if (answer_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived, expected 0, got %0d",
                     $time, answer_q.size(), answer_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/plfh_pkg.sv
hdl/plfh_tx_frame.sv
hdl/panel_link_frame_handler_core.sv
tb/panel_link_frame_handler_core_test.sv
